// ----- hw/rtl/ttip_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttip_pkg
// Types, constants and character helpers shared by the text-to-integer parser.
// ----------------------------------------------------------------------------
package ttip_pkg;

   typedef enum logic [2:0] {
      PH_SPACE,
      PH_SIGN,
      PH_ZERO,
      PH_XPEND,
      PH_DIGITS,
      PH_DONE
   } parse_phase_type;

   // classification of one input byte, as carried from front to back
   typedef struct packed {
      logic       terminator;
      logic       is_blank;
      logic       is_minus;
      logic       is_plus;
      logic       is_x;
      logic       is_zero_char;
      logic [5:0] digit;
   } char_class_type;

   localparam logic [5:0]  RADIX_MAX    = 6'd36;
   localparam logic [5:0]  RADIX_ONE    = 6'd1;
   localparam logic [5:0]  RADIX_AUTO   = 6'd0;
   localparam logic [5:0]  RADIX_OCT    = 6'd8;
   localparam logic [5:0]  RADIX_DEC    = 6'd10;
   localparam logic [5:0]  RADIX_HEX    = 6'd16;
   localparam logic [5:0]  DIGIT_NONE   = 6'd36;
   localparam logic [7:0]  CHAR_NUL     = 8'h00;
   localparam logic [7:0]  CHAR_SPACE   = 8'h20;
   localparam logic [7:0]  CHAR_MINUS   = 8'h2D;
   localparam logic [7:0]  CHAR_PLUS    = 8'h2B;
   localparam logic [7:0]  CHAR_ZERO    = 8'h30;
   localparam logic [7:0]  CHAR_NINE    = 8'h39;
   localparam logic [7:0]  CHAR_LOWER_A = 8'h61;
   localparam logic [7:0]  CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0]  CHAR_UPPER_A = 8'h41;
   localparam logic [7:0]  CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0]  CHAR_LOWER_X = 8'h78;
   localparam logic [7:0]  CHAR_UPPER_X = 8'h58;
   localparam logic [7:0]  CHAR_TAB     = 8'h09;
   localparam logic [7:0]  CHAR_CR      = 8'h0D;
   localparam logic [15:0] OUT_POS_MAX  = 16'hFFFF;

   // register word index within the configuration space
   localparam logic REG_NUMBER_BASE = 1'b0;

   function automatic logic radix_bad(input logic [5:0] r);
      return (r == RADIX_ONE) || (r > RADIX_MAX);
   endfunction

   function automatic logic [5:0] char_digit(input logic [7:0] c);
      logic [7:0] d;
      d = {2'b00, DIGIT_NONE};
      if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
         d = c - CHAR_ZERO;
      end else if (c inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
         d = c - CHAR_LOWER_A + 8'd10;
      end else if (c inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
         d = c - CHAR_UPPER_A + 8'd10;
      end
      return d[5:0];
   endfunction

endpackage

// ----- hw/rtl/ttip_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttip_front
// Accepts input bytes and classifies them for the parse engine.
// ----------------------------------------------------------------------------
module ttip_front (
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [7:0]               req_character,
   output logic                     push_valid,
   output ttip_pkg::char_class_type push_data,
   input  logic                     queue_full
);
   import ttip_pkg::*;

   assign req_stall  = queue_full;
   assign push_valid = req_valid && !queue_full;

   always_comb begin
      push_data.terminator   = (req_character == CHAR_NUL);
      push_data.is_blank     = (req_character == CHAR_SPACE) ||
                               (req_character inside {[CHAR_TAB:CHAR_CR]});
      push_data.is_minus     = (req_character == CHAR_MINUS);
      push_data.is_plus      = (req_character == CHAR_PLUS);
      push_data.is_x         = (req_character == CHAR_LOWER_X) ||
                               (req_character == CHAR_UPPER_X);
      push_data.is_zero_char = (req_character == CHAR_ZERO);
      push_data.digit        = char_digit(req_character);
   end

endmodule

// ----- hw/rtl/ttip_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttip_queue
// Two-entry queue of classified items between the front and the parse engine.
// ----------------------------------------------------------------------------
module ttip_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   input  ttip_pkg::char_class_type push_data,
   output logic                     full,
   output logic                     pop_valid,
   output ttip_pkg::char_class_type pop_data,
   input  logic                     pop_ready
);
   import ttip_pkg::*;

   char_class_type slot_ff [2];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;
   logic           do_pop;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_data  = slot_ff[rd_ptr_ff];
   assign do_pop    = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push_valid ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push_valid} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hw/rtl/ttip_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttip_back
// Parse engine: walks the phases, gathers digits and registers the result.
// ----------------------------------------------------------------------------
module ttip_back #(
   parameter int POSITION_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [5:0]               number_base,
   input  logic                     pop_valid,
   input  ttip_pkg::char_class_type pop_data,
   output logic                     pop_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [63:0]              rsp_value,
   output logic                     rsp_overflowed,
   output logic                     rsp_digits_found,
   output logic [15:0]              rsp_stop_position,
   output logic                     rsp_invalid_radix
);
   import ttip_pkg::*;

   localparam int EXT_W = (POSITION_BITS > 16) ? POSITION_BITS : 16;
   localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

   parse_phase_type           phase_ff, phase_in;
   logic [63:0]               acc_ff, acc_in;
   logic [5:0]                radix_ff, radix_in;
   logic                      neg_ff, neg_in;
   logic                      any_ff, any_in;
   logic                      ovf_ff, ovf_in;
   logic [POSITION_BITS-1:0]  byte_ff, byte_in;
   logic [POSITION_BITS-1:0]  stop_ff, stop_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [63:0]               value_ff, value_in;
   logic                      ovf_out_ff, ovf_out_in;
   logic                      found_ff, found_in;
   logic [15:0]               pos_ff, pos_in;
   logic                      bad_out_ff, bad_out_in;

   char_class_type            cc;
   logic                      step;
   logic                      term_step;
   logic                      begin_body;
   logic                      cfg_bad;
   logic                      cfg_auto;
   logic                      zero_mark;
   logic                      take_en;
   logic [5:0]                take_radix;
   logic                      digit_ok;
   logic                      take_ok;
   logic [69:0]               prod;
   logic [POSITION_BITS-1:0]  pos_inc;
   logic [5:0]                term_radix;
   logic                      term_bad;
   logic [EXT_W-1:0]          stop_ext;

   assign cc        = pop_data;
   // an ending item waits for the result register to free up
   assign pop_ready = !cc.terminator || !rsp_valid_ff || !rsp_stall;
   assign step      = pop_valid && pop_ready;
   assign term_step = step && cc.terminator;

   assign cfg_bad    = radix_bad(number_base);
   assign cfg_auto   = (number_base == RADIX_AUTO);
   assign begin_body = ((phase_ff == PH_SPACE) && !cc.is_blank && !cc.is_minus &&
                        !cc.is_plus) || (phase_ff == PH_SIGN);
   assign zero_mark  = begin_body && !cfg_bad && cfg_auto && cc.is_zero_char;

   always_comb begin
      if (begin_body) begin
         take_radix = cfg_auto ? RADIX_DEC : number_base;
      end else if (phase_ff == PH_XPEND) begin
         take_radix = RADIX_HEX;
      end else begin
         take_radix = radix_ff;
      end
   end

   assign take_en  = (begin_body && !cfg_bad && !zero_mark) ||
                     ((phase_ff == PH_ZERO) && !cc.is_x) ||
                     ((phase_ff == PH_XPEND) && (cc.digit < RADIX_HEX)) ||
                     (phase_ff == PH_DIGITS);
   assign digit_ok = (take_radix >= 6'd2) && (cc.digit < take_radix);
   assign take_ok  = take_en && digit_ok;
   assign prod     = 70'(acc_ff) * 70'(take_radix) + 70'(cc.digit);
   assign pos_inc  = (byte_ff == POS_MAX) ? byte_ff : byte_ff + 1'b1;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         if (cc.terminator) begin
            phase_in = PH_SPACE;
         end else begin
            case (phase_ff)
               PH_SPACE, PH_SIGN: begin
                  if (phase_ff == PH_SPACE && cc.is_blank) begin
                     phase_in = PH_SPACE;
                  end else if (phase_ff == PH_SPACE && (cc.is_minus || cc.is_plus)) begin
                     phase_in = PH_SIGN;
                  end else if (cfg_bad) begin
                     phase_in = PH_DONE;
                  end else if (zero_mark) begin
                     phase_in = PH_ZERO;
                  end else begin
                     phase_in = digit_ok ? PH_DIGITS : PH_DONE;
                  end
               end
               PH_ZERO: begin
                  if (cc.is_x) begin
                     phase_in = PH_XPEND;
                  end else begin
                     phase_in = digit_ok ? PH_DIGITS : PH_DONE;
                  end
               end
               PH_XPEND: begin
                  phase_in = take_ok ? PH_DIGITS : PH_DONE;
               end
               PH_DIGITS: begin
                  phase_in = digit_ok ? PH_DIGITS : PH_DONE;
               end
               default: begin
                  phase_in = PH_DONE;
               end
            endcase
         end
      end
   end

   // parse state update
   always_comb begin
      acc_in   = acc_ff;
      radix_in = radix_ff;
      neg_in   = neg_ff;
      any_in   = any_ff;
      ovf_in   = ovf_ff;
      byte_in  = byte_ff;
      stop_in  = stop_ff;
      if (term_step) begin
         acc_in   = '0;
         radix_in = RADIX_AUTO;
         neg_in   = 1'b0;
         any_in   = 1'b0;
         ovf_in   = 1'b0;
         byte_in  = '0;
         stop_in  = '0;
      end else if (step) begin
         byte_in = pos_inc;
         if (phase_ff == PH_SPACE && cc.is_minus) begin
            neg_in = 1'b1;
         end
         if (begin_body) begin
            radix_in = cfg_auto ? (cc.is_zero_char ? RADIX_OCT : RADIX_DEC) : number_base;
         end else if (phase_ff == PH_XPEND && take_ok) begin
            radix_in = RADIX_HEX;
         end
         if (take_ok || zero_mark) begin
            any_in  = 1'b1;
            stop_in = pos_inc;
         end
         if (take_ok && !ovf_ff) begin
            acc_in = prod[63:0];
            ovf_in = (prod[69:64] != 6'd0);
         end
      end
   end

   // result formation
   always_comb begin
      term_radix = (phase_ff == PH_SPACE || phase_ff == PH_SIGN) ? number_base : radix_ff;
      term_bad   = radix_bad(term_radix);
      stop_ext   = EXT_W'(stop_ff);
      if (term_bad) begin
         value_in = '0;
      end else if (ovf_ff) begin
         value_in = '1;
      end else if (neg_ff) begin
         value_in = 64'd0 - acc_ff;
      end else begin
         value_in = acc_ff;
      end
      ovf_out_in = !term_bad && ovf_ff;
      found_in   = !term_bad && any_ff;
      bad_out_in = term_bad;
      if (!found_in) begin
         pos_in = '0;
      end else if (stop_ext > EXT_W'(OUT_POS_MAX)) begin
         pos_in = OUT_POS_MAX;
      end else begin
         pos_in = stop_ext[15:0];
      end
      if (term_step) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SPACE;
         acc_ff       <= '0;
         radix_ff     <= RADIX_AUTO;
         neg_ff       <= 1'b0;
         any_ff       <= 1'b0;
         ovf_ff       <= 1'b0;
         byte_ff      <= '0;
         stop_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         acc_ff       <= acc_in;
         radix_ff     <= radix_in;
         neg_ff       <= neg_in;
         any_ff       <= any_in;
         ovf_ff       <= ovf_in;
         byte_ff      <= byte_in;
         stop_ff      <= stop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the result payload until it is taken
   always_ff @(posedge clock) begin
      if (term_step) begin
         value_ff   <= value_in;
         ovf_out_ff <= ovf_out_in;
         found_ff   <= found_in;
         pos_ff     <= pos_in;
         bad_out_ff <= bad_out_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_value         = value_ff;
   assign rsp_overflowed    = ovf_out_ff;
   assign rsp_digits_found  = found_ff;
   assign rsp_stop_position = pos_ff;
   assign rsp_invalid_radix = bad_out_ff;

endmodule

// ----- hw/rtl/text_to_integer_parser_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_to_integer_parser_top
// Streaming text to 64-bit integer parser with a number_base register.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while req_stall is low; the parse engine does one
// multiply-add a byte. Result path: the ending zero byte is written into the
// two-entry queue, then the parse engine writes the result register; bytes
// waiting in the queue or a stalled result hold the result back.
// Reset: synchronous; clears the queue, the parse state, the pending result
// and number_base (automatic base detection).
module text_to_integer_parser_top #(
   parameter int POSITION_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_character,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_value,
   output logic        rsp_overflowed,
   output logic        rsp_digits_found,
   output logic [15:0] rsp_stop_position,
   output logic        rsp_invalid_radix,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import ttip_pkg::*;

   logic [5:0]     base_ff, base_in;
   logic           csr_write;
   logic           push_valid;
   char_class_type push_data;
   logic           queue_full;
   logic           pop_valid;
   char_class_type pop_data;
   logic           pop_ready;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready && (paddr[2] == REG_NUMBER_BASE);
   assign base_in   = csr_write ? pwdata[5:0] : base_ff;
   assign prdata    = (paddr[2] == REG_NUMBER_BASE) ? {26'd0, base_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= RADIX_AUTO;
      end else begin
         base_ff <= base_in;
      end
   end

   ttip_front u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_character (req_character),
      .push_valid    (push_valid),
      .push_data     (push_data),
      .queue_full    (queue_full)
   );

   ttip_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready)
   );

   ttip_back #(
      .POSITION_BITS (POSITION_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .number_base       (base_ff),
      .pop_valid         (pop_valid),
      .pop_data          (pop_data),
      .pop_ready         (pop_ready),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_value         (rsp_value),
      .rsp_overflowed    (rsp_overflowed),
      .rsp_digits_found  (rsp_digits_found),
      .rsp_stop_position (rsp_stop_position),
      .rsp_invalid_radix (rsp_invalid_radix)
   );

endmodule

// ----- tb/sv/tb_text_to_integer_parser_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_to_integer_parser_top
// Self-checking bench for the streaming text-to-integer parser.
// A scoreboard predicts each parse result from the accepted characters and the
// current number_base; strings are sent in random bursts while the result
// side stalls on its own pattern, with one long hold-off to fill the queue.
// ----------------------------------------------------------------------------
module tb_text_to_integer_parser_top;
   import ttip_pkg::*;

   localparam int          CYCLE_LIMIT    = 4_000_000;
   localparam int          DRAIN_CYCLES   = 8;
   localparam int          HOLD_CYCLES    = 150;
   localparam int          PHASE_ITEMS    = 40;
   localparam int          PRESSURE_TEXTS = 20;
   localparam logic [15:0] POS_LIMIT      = 16'hFFFF;
   localparam logic [2:0]  BASE_ADDR      = {REG_NUMBER_BASE, 2'b00};

   typedef struct packed {
      logic [63:0] value;
      logic        overflowed;
      logic        digits_found;
      logic [15:0] stop_position;
      logic        invalid_radix;
   } parse_result_type;

   class parse_scoreboard;
      parse_result_type parsed_values[$];
      int              error_count;
      logic [5:0]      number_base;
      parse_phase_type phase;
      logic [63:0]     acc;
      logic [5:0]      radix;
      logic            negative;
      logic            any_digit;
      logic            overflow_seen;
      logic [15:0]     position;
      logic [15:0]     stop_offset;

      function new();
         error_count  = 0;
         number_base  = RADIX_AUTO;
         clear();
      endfunction

      function void clear();
         phase         = PH_SPACE;
         acc           = '0;
         radix         = '0;
         negative      = 1'b0;
         any_digit     = 1'b0;
         overflow_seen = 1'b0;
         position      = '0;
         stop_offset   = '0;
      endfunction

      function int pending();
         return parsed_values.size();
      endfunction

      function bit base_bad(logic [5:0] r);
         return r == RADIX_ONE || r > RADIX_MAX;
      endfunction

      function int digit_of(logic [7:0] c);
         if (c >= CHAR_ZERO && c <= CHAR_NINE) return c - CHAR_ZERO;
         if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) return c - CHAR_LOWER_A + 10;
         if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) return c - CHAR_UPPER_A + 10;
         return 36;
      endfunction

      function void mark_digit();
         any_digit   = 1'b1;
         stop_offset = (position < POS_LIMIT) ? position + 16'd1 : POS_LIMIT;
      endfunction

      function void add_digit(logic [7:0] c);
         int          v;
         logic [71:0] wide;
         v = digit_of(c);
         if (radix < 2 || v >= radix) begin
            phase = PH_DONE;
            return;
         end
         mark_digit();
         if (!overflow_seen) begin
            wide = 72'(acc) * 72'(radix) + 72'(v);
            if (wide[71:64] != '0) overflow_seen = 1'b1;
            acc = wide[63:0];
         end
      endfunction

      function void start_body(logic [7:0] c);
         radix = number_base;
         if (base_bad(radix)) begin
            phase = PH_DONE;
         end else if (radix == RADIX_AUTO) begin
            if (c == CHAR_ZERO) begin
               // the leading zero is itself an octal digit
               radix = RADIX_OCT;
               mark_digit();
               phase = PH_ZERO;
            end else begin
               radix = RADIX_DEC;
               phase = PH_DIGITS;
               add_digit(c);
            end
         end else begin
            phase = PH_DIGITS;
            add_digit(c);
         end
      endfunction

      function void finish_text();
         parse_result_type r;
         logic          bad;
         if (phase == PH_SPACE || phase == PH_SIGN) radix = number_base;
         bad = base_bad(radix);
         if (bad) r.value = '0;
         else if (overflow_seen) r.value = '1;
         else if (negative) r.value = -acc;
         else r.value = acc;
         r.overflowed    = !bad && overflow_seen;
         r.digits_found  = !bad && any_digit;
         r.stop_position = (!bad && any_digit) ? stop_offset : 16'd0;
         r.invalid_radix = bad;
         parsed_values.push_back(r);
         clear();
      endfunction

      function void take_character(logic [7:0] c);
         if (c == CHAR_NUL) begin
            finish_text();
            return;
         end
         case (phase)
            PH_SPACE: begin
               if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)) begin
                  // skip white space
               end else if (c == CHAR_MINUS) begin
                  negative = 1'b1;
                  phase    = PH_SIGN;
               end else if (c == CHAR_PLUS) begin
                  phase = PH_SIGN;
               end else begin
                  start_body(c);
               end
            end
            PH_SIGN: start_body(c);
            PH_ZERO: begin
               if (c == CHAR_LOWER_X || c == CHAR_UPPER_X) begin
                  phase = PH_XPEND;
               end else begin
                  phase = PH_DIGITS;
                  add_digit(c);
               end
            end
            PH_XPEND: begin
               if (digit_of(c) < 16) begin
                  radix = RADIX_HEX;
                  phase = PH_DIGITS;
                  add_digit(c);
               end else begin
                  phase = PH_DONE;
               end
            end
            PH_DIGITS: add_digit(c);
            default: phase = PH_DONE;
         endcase
         if (position != POS_LIMIT) position++;
      endfunction

      task report(string what, logic [63:0] got, logic [63:0] wanted);
         $display("%0t mismatch %s: got %0h, expected %0h", $time, what, got, wanted);
         error_count++;
      endtask

      task compare_result(logic [63:0] value, logic overflowed, logic digits_found,
                          logic [15:0] stop_position, logic invalid_radix);
         parse_result_type want;
         if (parsed_values.size() == 0) begin
            report("result with nothing expected", value, 64'd0);
            return;
         end
         want = parsed_values.pop_front();
         if (value !== want.value) report("value", value, want.value);
         if (overflowed !== want.overflowed)
            report("overflowed", 64'(overflowed), 64'(want.overflowed));
         if (digits_found !== want.digits_found)
            report("digits_found", 64'(digits_found), 64'(want.digits_found));
         if (stop_position !== want.stop_position)
            report("stop_position", 64'(stop_position), 64'(want.stop_position));
         if (invalid_radix !== want.invalid_radix)
            report("invalid_radix", 64'(invalid_radix), 64'(want.invalid_radix));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_character = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_value;
   logic        rsp_overflowed;
   logic        rsp_digits_found;
   logic [15:0] rsp_stop_position;
   logic        rsp_invalid_radix;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   parse_scoreboard parse_sb;
   logic [7:0]      text_bytes[$];
   int              burst_left = 0;
   int              gap_max = 0;
   int              cycles = 0;
   bit              hold_done = 1'b0;
   bit              hold_request = 1'b0;

   text_to_integer_parser_top i_dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_text_to_integer_parser_top: done, errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         parse_sb.compare_result(rsp_value, rsp_overflowed, rsp_digits_found,
                                 rsp_stop_position, rsp_invalid_radix);
   end

   // result side: changing stall modes, plus one long hold-off to back up the queue
   initial begin
      int mode;
      int count;
      mode  = 0;
      count = 0;
      forever begin
         @(negedge clock);
         if (!hold_done && !reset && hold_request) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         if (count == 0) begin
            mode  = $urandom_range(0, 3);
            count = $urandom_range(16, 96);
         end
         count--;
         case (mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= ~rsp_stall;
         endcase
      end
   end

   task automatic send_byte(input logic [7:0] c);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (gap_max != 0) begin
            @(negedge clock);
            req_valid     <= 1'b0;
            req_character <= 8'($urandom);
            repeat ($urandom_range(1, gap_max)) @(posedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid     <= 1'b1;
      req_character <= c;
      do @(posedge clock); while (req_stall);
      parse_sb.take_character(c);
   endtask

   task automatic send_text();
      for (int i = 0; i < text_bytes.size(); i++) send_byte(text_bytes[i]);
   endtask

   task automatic send_string(input string s);
      text_bytes.delete();
      for (int i = 0; i < s.len(); i++) text_bytes.push_back(s[i]);
      text_bytes.push_back(CHAR_NUL);
      send_text();
   endtask

   function automatic logic [7:0] pick_blank();
      int w;
      w = $urandom_range(8, 13);
      return (w == 8) ? CHAR_SPACE : 8'(w);
   endfunction

   // mostly well-formed numbers with random content, the rest noise
   task automatic build_text(input logic [5:0] base);
      int eff;
      int count;
      int r;
      int v;
      text_bytes.delete();
      if ($urandom_range(0, 9) < 2) begin
         repeat ($urandom_range(0, 8)) text_bytes.push_back(8'($urandom_range(1, 255)));
      end else begin
         repeat ($urandom_range(0, 3)) text_bytes.push_back(pick_blank());
         case ($urandom_range(0, 3))
            0: text_bytes.push_back(CHAR_MINUS);
            1: text_bytes.push_back(CHAR_PLUS);
            default: ;
         endcase
         eff = base;
         if (base == RADIX_AUTO) begin
            case ($urandom_range(0, 3))
               0: begin
                  text_bytes.push_back(CHAR_ZERO);
                  text_bytes.push_back($urandom_range(0, 1) ? CHAR_LOWER_X : CHAR_UPPER_X);
                  eff = RADIX_HEX;
               end
               1: begin
                  text_bytes.push_back(CHAR_ZERO);
                  eff = RADIX_OCT;
               end
               default: eff = RADIX_DEC;
            endcase
         end else if (base == RADIX_ONE || base > RADIX_MAX) begin
            eff = RADIX_DEC;
         end
         r = $urandom_range(0, 19);
         if (r == 0) count = 0;
         else if (r < 15) count = $urandom_range(1, 8);
         else if (r < 19) count = $urandom_range(9, 25);
         else count = $urandom_range(26, 70);
         repeat (count) begin
            if ($urandom_range(0, 15) == 0) v = $urandom_range(0, 35);
            else v = $urandom_range(0, eff - 1);
            if (v < 10) text_bytes.push_back(CHAR_ZERO + 8'(v));
            else text_bytes.push_back(($urandom_range(0, 1) ? CHAR_LOWER_A : CHAR_UPPER_A)
                                      + 8'(v - 10));
         end
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4)) text_bytes.push_back(8'($urandom_range(1, 255)));
      end
      text_bytes.push_back(CHAR_NUL);
   endtask

   // drop valid, let every pending result arrive, then let the pipeline drain
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (parse_sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic is_write, input logic [31:0] data,
                             output logic [31:0] rd);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= BASE_ADDR;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rd = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_number_base(input logic [5:0] v);
      logic [31:0] rd;
      wait_idle();
      csr_access(1'b1, 32'(v), rd);
      parse_sb.number_base = v;
      csr_access(1'b0, 32'd0, rd);
      if (rd[5:0] !== v) parse_sb.report("number_base readback", 64'(rd[5:0]), 64'(v));
   endtask

   initial begin
      logic [5:0] base_plan[10];
      int         sent;
      parse_sb = new();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty, octal zero, bare hex prefix, signs, overflow, top byte, bad base
      gap_max = 3;
      set_number_base(RADIX_AUTO);
      send_string("");
      send_string("0");
      send_string("0xg");
      send_string("\t-0X1f");
      send_string("+07z");
      send_string("0x1ffffffffffffffff");
      text_bytes.delete();
      text_bytes.push_back(8'hFF);
      text_bytes.push_back(CHAR_ZERO + 8'd5);
      text_bytes.push_back(CHAR_NUL);
      send_text();
      set_number_base(RADIX_ONE);
      send_string("-5");
      send_string("");

      // short items keep coming while the result side holds off
      set_number_base(RADIX_DEC);
      hold_request = 1'b1;
      repeat (PRESSURE_TEXTS) send_string("7");

      base_plan = '{RADIX_DEC, RADIX_HEX, 6'd2, RADIX_MAX, RADIX_ONE,
                    RADIX_OCT, RADIX_AUTO, 6'd37, 6'd63, 6'd0};
      base_plan[9] = 6'($urandom_range(2, 36));
      for (int p = 0; p < 10; p++) begin
         gap_max = (p % 3 == 0) ? 0 : $urandom_range(2, 8);
         set_number_base(base_plan[p]);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            build_text(base_plan[p]);
            send_text();
            sent += text_bytes.size();
         end
      end

      wait_idle();
      if (parse_sb.error_count == 0) begin
         $display("tb_text_to_integer_parser_top: done, clean");
      end else begin
         $display("tb_text_to_integer_parser_top: done, errors");
      end
      $finish;
   end

endmodule
